// ===== rtl/dngr_pkg.sv =====
`timescale 1ns / 1ps
// dngr_pkg: shared types, constants and helpers for the decimal glyph renderer
// no dependencies; used by decimal_number_glyph_renderer_core
package dngr_pkg;

  localparam int GLYPH_W         = 5;
  localparam int GLYPH_H         = 7;
  localparam int NUM_DIGITS      = 10;
  localparam int BIN_W           = 32;
  localparam int BCD_W           = 4 * NUM_DIGITS;
  localparam int MASK_W          = GLYPH_W * GLYPH_H;
  localparam int CELL_PITCH      = 6;
  localparam int DABBLE_STAGES   = 4;
  localparam int STEPS_PER_STAGE = BIN_W / DABBLE_STAGES;

  localparam logic [15:0] FRAME_W_RST = 16'd640;
  localparam logic [15:0] FRAME_H_RST = 16'd480;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  typedef logic [BCD_W-1:0] bcd_t;

  typedef struct packed {
    bcd_t        bcd;
    logic [31:0] bin;
    logic [15:0] ox;
    logic [15:0] oy;
  } dabble_t;

  // font rows, row 0 in the top five bits, msb of a row is the leftmost column
  localparam logic [MASK_W-1:0] FONT [NUM_DIGITS] = '{
    {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
  };

  // one slice of shift-and-add-3 binary to bcd conversion
  function automatic dabble_t dabble_slice(input dabble_t s);
    dabble_t r;
    r = s;
    for (int st = 0; st < STEPS_PER_STAGE; st++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (r.bcd[d*4 +: 4] >= 4'd5) begin
          r.bcd[d*4 +: 4] = r.bcd[d*4 +: 4] + 4'd3;
        end
      end
      r.bcd = {r.bcd[BCD_W-2:0], r.bin[BIN_W-1]};
      r.bin = {r.bin[BIN_W-2:0], 1'b0};
    end
    return r;
  endfunction

  // position of the most significant nonzero digit, zero when all digits are zero
  function automatic logic [3:0] top_digit(input bcd_t b);
    logic [3:0] idx;
    idx = 4'd0;
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (b[d*4 +: 4] != 4'd0) begin
        idx = 4'(d);
      end
    end
    return idx;
  endfunction

  // glyph bits arranged as bit row*5+col, col 0 leftmost
  function automatic logic [MASK_W-1:0] glyph_bits(input logic [3:0] digit);
    logic [MASK_W-1:0] rows;
    logic [MASK_W-1:0] m;
    rows = '0;
    m    = '0;
    if (digit <= 4'd9) begin
      rows = FONT[digit];
    end
    for (int r = 0; r < GLYPH_H; r++) begin
      for (int c = 0; c < GLYPH_W; c++) begin
        m[r*GLYPH_W + c] = rows[(GLYPH_H-1-r)*GLYPH_W + (GLYPH_W-1-c)];
      end
    end
    return m;
  endfunction

endpackage

// ===== rtl/decimal_number_glyph_renderer_core.sv =====
`timescale 1ns / 1ps
// decimal_number_glyph_renderer_core: number to decimal 5x7 glyph cells
// depends on dngr_pkg (types, font, conversion helpers)
//
//   channel | direction | handshake          | word
//   --------+-----------+--------------------+-------------------------------------
//   in_     | input     | in_valid/in_stall  | origin_x, origin_y, number_value
//   out_    | output    | out_valid/out_stall| cell_x, cell_y, digit_code, mask, last
//   cfg_    | input     | cfg_we             | cfg_index selects width or height
//
// a number passes four conversion stages (eight shift-add-3 steps each), then
// enters the digit emitter, which sends one digit cell per cycle into the output
// register while the output is not stalled; the first digit passes the stage, emitter
// and output registers; throughput is set by the single digit emitter, which sends
// a number's 1 to 10 digits back to back and loads the next as the last one leaves
// rst_n is synchronous: clears all valid bits and loads frame size 640 x 480
// a stalled output holds its word; stalls back up stage by stage, nothing lost
module decimal_number_glyph_renderer_core (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // number in
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_origin_x,
  input  logic [15:0] in_origin_y,
  input  logic [31:0] in_number_value,
  // digit cells out
  output logic        out_valid,
  input  logic        out_stall,
  output logic [16:0] out_cell_x,
  output logic [15:0] out_cell_y,
  output logic [3:0]  out_digit_code,
  output logic [34:0] out_pixel_mask,
  output logic        out_last_digit
);

  localparam int NS = dngr_pkg::DABBLE_STAGES;

  // frame size registers
  logic [15:0] frame_w_r;
  logic [15:0] frame_h_r;

  // conversion pipeline
  dngr_pkg::dabble_t s_r   [NS];
  dngr_pkg::dabble_t s_in  [NS];
  dngr_pkg::dabble_t s_nxt [NS];
  logic [NS-1:0]     s_valid_r;
  logic [NS-1:0]     s_up_valid;
  logic [NS:0]       s_ready;

  // digit emitter
  logic              em_valid_r;
  dngr_pkg::bcd_t    em_bcd_r;
  logic [3:0]        em_idx_r;
  logic [16:0]       em_cx_r;
  logic [15:0]       em_oy_r;
  logic              em_ready;
  logic              em_load;
  logic              em_fire;
  logic              em_last;
  logic [3:0]        em_digit;
  logic [34:0]       em_glyph;
  logic [34:0]       em_mask;
  logic [dngr_pkg::GLYPH_W-1:0] col_ok;
  logic [dngr_pkg::GLYPH_H-1:0] row_ok;

  // output register
  logic              out_valid_r;
  logic [16:0]       out_cell_x_r;
  logic [15:0]       out_cell_y_r;
  logic [3:0]        out_digit_code_r;
  logic [34:0]       out_pixel_mask_r;
  logic              out_last_digit_r;
  logic              out_free;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= dngr_pkg::FRAME_W_RST;
      frame_h_r <= dngr_pkg::FRAME_H_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        dngr_pkg::CFG_FRAME_WIDTH:  frame_w_r <= cfg_wdata;
        dngr_pkg::CFG_FRAME_HEIGHT: frame_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // output side handshake
  assign out_free = !out_valid_r || !out_stall;
  assign em_last  = (em_idx_r == 4'd0);
  assign em_fire  = em_valid_r && out_free;
  assign em_ready = !em_valid_r || (out_free && em_last);
  assign em_load  = s_valid_r[NS-1] && em_ready;

  // stage inputs, slice logic and backward ready chain
  always_comb begin
    s_in[0]       = '{bcd: '0, bin: in_number_value, ox: in_origin_x, oy: in_origin_y};
    s_up_valid[0] = in_valid;
    for (int k = 1; k < NS; k++) begin
      s_in[k]       = s_r[k-1];
      s_up_valid[k] = s_valid_r[k-1];
    end
    for (int k = 0; k < NS; k++) begin
      s_nxt[k] = dngr_pkg::dabble_slice(s_in[k]);
    end
    s_ready[NS] = em_ready;
    for (int k = NS - 1; k >= 0; k--) begin
      s_ready[k] = !s_valid_r[k] || s_ready[k+1];
    end
  end

  assign in_stall = !s_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (s_ready[k]) begin
          s_valid_r[k] <= s_up_valid[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NS; k++) begin
      if (s_ready[k] && s_up_valid[k]) begin
        s_r[k] <= s_nxt[k];
      end
    end
  end

  // digit select, font lookup and frame clipping for the current cell
  always_comb begin
    em_digit = em_bcd_r[em_idx_r*4 +: 4];
    em_glyph = dngr_pkg::glyph_bits(em_digit);
    for (int c = 0; c < dngr_pkg::GLYPH_W; c++) begin
      col_ok[c] = ({1'b0, em_cx_r} + 18'(c)) < {2'b00, frame_w_r};
    end
    for (int r = 0; r < dngr_pkg::GLYPH_H; r++) begin
      row_ok[r] = ({1'b0, em_oy_r} + 17'(r)) < {1'b0, frame_h_r};
    end
    for (int r = 0; r < dngr_pkg::GLYPH_H; r++) begin
      for (int c = 0; c < dngr_pkg::GLYPH_W; c++) begin
        em_mask[r*dngr_pkg::GLYPH_W + c] =
          em_glyph[r*dngr_pkg::GLYPH_W + c] & col_ok[c] & row_ok[r];
      end
    end
  end

  // emitter and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (em_load) begin
        em_valid_r <= 1'b1;
      end else if (em_fire && em_last) begin
        em_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= em_valid_r;
      end
    end
  end

  // emitter and output payload
  always_ff @(posedge clk) begin
    if (em_load) begin
      em_bcd_r <= s_r[NS-1].bcd;
      em_idx_r <= dngr_pkg::top_digit(s_r[NS-1].bcd);
      em_cx_r  <= {1'b0, s_r[NS-1].ox};
      em_oy_r  <= s_r[NS-1].oy;
    end else if (em_fire) begin
      em_idx_r <= em_idx_r - 4'd1;
      em_cx_r  <= em_cx_r + 17'(dngr_pkg::CELL_PITCH);
    end
    if (em_fire) begin
      out_cell_x_r     <= em_cx_r;
      out_cell_y_r     <= em_oy_r;
      out_digit_code_r <= em_digit;
      out_pixel_mask_r <= em_mask;
      out_last_digit_r <= em_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_x     = out_cell_x_r;
  assign out_cell_y     = out_cell_y_r;
  assign out_digit_code = out_digit_code_r;
  assign out_pixel_mask = out_pixel_mask_r;
  assign out_last_digit = out_last_digit_r;

`ifndef SYNTHESIS
  // digit pointer stays within the ten bcd digits
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    em_valid_r |-> (em_idx_r <= 4'd9))
    else $error("digit pointer out of range");

  // a number's digits leave back to back
  a_digits_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_digit_r && !out_stall) |=> out_valid_r)
    else $error("gap inside a number's digit run");

  // consecutive cells of one number step by the cell pitch
  a_cell_pitch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_digit_r && !out_stall) |=>
      (out_cell_x_r == $past(out_cell_x_r) + 17'(dngr_pkg::CELL_PITCH)))
    else $error("cell column did not advance by the pitch");

  // last conversion stage holds while the emitter is busy
  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s_valid_r[NS-1] && !em_ready) |=> (s_valid_r[NS-1] && $stable(s_r[NS-1])))
    else $error("conversion stage changed under backpressure");
`endif

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for decimal_number_glyph_renderer_core
// depends on dngr_pkg (register indexes) and the core rtl; nothing else
module tb;

  // one rendered digit cell as seen on the out_ channel
  typedef struct packed {
    logic [16:0] cell_x;
    logic [15:0] cell_y;
    logic [3:0]  digit_code;
    logic [34:0] pixel_mask;
    logic        last_digit;
  } digit_cell_t;

  // predicts the digit cells of each accepted number and checks the outgoing words
  class glyph_cell_board;
    int unsigned frame_w;
    int unsigned frame_h;
    digit_cell_t cells_due[$];
    int          fail_count;

    function new();
      frame_w    = 640;
      frame_h    = 480;
      fail_count = 0;
    endfunction

    function void set_frame(logic idx, logic [15:0] value);
      if (idx == dngr_pkg::CFG_FRAME_WIDTH) frame_w = 32'(value);
      else frame_h = 32'(value);
    endfunction

    // 5x7 font, row 0 in the top five bits, msb of a row is the left column
    function logic [34:0] font_of(int unsigned d);
      case (d)
        0: return {5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14};
        1: return {5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14};
        2: return {5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31};
        3: return {5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30};
        4: return {5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2};
        5: return {5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30};
        6: return {5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14};
        7: return {5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8};
        8: return {5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14};
        9: return {5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14};
        default: return '0;
      endcase
    endfunction

    // lit pixels of one cell, clipped to the frame; coordinates never wrap
    function logic [34:0] clipped_mask(int unsigned d, int unsigned left, int unsigned top);
      logic [34:0] rows;
      logic [34:0] m;
      rows = font_of(d);
      m    = '0;
      for (int r = 0; r < 7; r++) begin
        for (int c = 0; c < 5; c++) begin
          if (rows[(6 - r) * 5 + (4 - c)] && (left + c < frame_w) && (top + r < frame_h))
            m[r * 5 + c] = 1'b1;
        end
      end
      return m;
    endfunction

    // split into decimal digits, msd first, and queue one cell per digit
    function void render_number(logic [15:0] ox, logic [15:0] oy, logic [31:0] val);
      int unsigned v;
      int unsigned digs[10];
      int          n;
      int unsigned cx;
      digit_cell_t c;
      v = val;
      n = 0;
      do begin
        digs[n] = v % 10;
        v       = v / 10;
        n++;
      end while (v != 0 && n < 10);
      for (int i = 0; i < n; i++) begin
        cx           = 32'(ox) + 32'(6 * i);
        c.cell_x     = cx[16:0];
        c.cell_y     = oy;
        c.digit_code = digs[n - 1 - i][3:0];
        c.pixel_mask = clipped_mask(digs[n - 1 - i], cx, 32'(oy));
        c.last_digit = (i == n - 1);
        cells_due.push_back(c);
      end
    endfunction

    function void check_cell(digit_cell_t got);
      digit_cell_t want;
      if (cells_due.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("%0t: unexpected digit cell x=%0d y=%0d digit=%0d mask=%h last=%0b",
                   $time, got.cell_x, got.cell_y, got.digit_code, got.pixel_mask,
                   got.last_digit);
        return;
      end
      want = cells_due.pop_front();
      if (got.cell_x !== want.cell_x || got.cell_y !== want.cell_y ||
          got.digit_code !== want.digit_code || got.pixel_mask !== want.pixel_mask ||
          got.last_digit !== want.last_digit) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("%0t: digit cell mismatch", $time);
          $display("  expected x=%0d y=%0d digit=%0d mask=%h last=%0b", want.cell_x,
                   want.cell_y, want.digit_code, want.pixel_mask, want.last_digit);
          $display("  actual   x=%0d y=%0d digit=%0d mask=%h last=%0b", got.cell_x,
                   got.cell_y, got.digit_code, got.pixel_mask, got.last_digit);
        end
      end
    endfunction

    function int pending();
      return cells_due.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_origin_x;
  logic [15:0] in_origin_y;
  logic [31:0] in_number_value;
  logic        out_valid;
  logic        out_stall;
  logic [16:0] out_cell_x;
  logic [15:0] out_cell_y;
  logic [3:0]  out_digit_code;
  logic [34:0] out_pixel_mask;
  logic        out_last_digit;

  glyph_cell_board board;
  bit              quiet;      // no idling on either side once set
  int              stall_left;

  decimal_number_glyph_renderer_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_origin_x     (in_origin_x),
    .in_origin_y     (in_origin_y),
    .in_number_value (in_number_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cell_x      (out_cell_x),
    .out_cell_y      (out_cell_y),
    .out_digit_code  (out_digit_code),
    .out_pixel_mask  (out_pixel_mask),
    .out_last_digit  (out_last_digit)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // generous hard limit: slowest run is well under a tenth of this
  initial begin
    #5_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // receiver side: random stall bursts, changed on the falling edge
  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) stall_left--;
      else if (!quiet && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 8);
      out_stall <= (stall_left != 0);
    end
  end

  // every accepted output word is checked against the oldest predicted cell
  always @(posedge clk) begin : cell_monitor
    digit_cell_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.cell_x     = out_cell_x;
      got.cell_y     = out_cell_y;
      got.digit_code = out_digit_code;
      got.pixel_mask = out_pixel_mask;
      got.last_digit = out_last_digit;
      board.check_cell(got);
    end
  end

  // sender rests with valid low and scrambled payload; n sets the length of the rest
  task automatic rest_sender(input int n);
    @(negedge clk);
    in_valid        <= 1'b0;
    in_origin_x     <= 16'($urandom);
    in_origin_y     <= 16'($urandom);
    in_number_value <= $urandom;
    repeat (n - 1) @(negedge clk);
  endtask

  // offer one number word and hold it until the core takes it
  task automatic send_number(input logic [15:0] ox, input logic [15:0] oy,
                             input logic [31:0] val);
    if (!quiet && $urandom_range(0, 3) == 0) rest_sender($urandom_range(1, 8));
    @(negedge clk);
    in_valid        <= 1'b1;
    in_origin_x     <= ox;
    in_origin_y     <= oy;
    in_number_value <= val;
    do @(posedge clk); while (in_stall);
    board.render_number(ox, oy, val);
  endtask

  // drop valid and wait until every predicted cell has come out, then a short tail
  task automatic drain_cells();
    rest_sender(1);
    while (board.pending() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  // one register write; only called while the core is idle
  task automatic write_frame_reg(input logic idx, input logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    board.set_frame(idx, value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // digit count chosen first so short and long numbers are equally common
  function automatic logic [31:0] pick_number();
    int          n;
    longint unsigned lo;
    longint unsigned hi;
    if ($urandom_range(0, 9) == 0) return $urandom;
    if ($urandom_range(0, 19) == 0) return 32'd0;
    n  = $urandom_range(1, 10);
    lo = 1;
    for (int i = 1; i < n; i++) lo = lo * 10;
    hi = lo * 10 - 1;
    if (n == 1) lo = 0;
    if (hi > 64'hFFFF_FFFF) hi = 64'hFFFF_FFFF;
    return $urandom_range(32'(hi), 32'(lo));
  endfunction

  // coordinates mostly straddle the frame edge or the top of the 16-bit range
  function automatic logic [15:0] pick_coord(input int unsigned limit);
    int e;
    case ($urandom_range(0, 3))
      0, 1: begin
        e = int'(limit) - int'($urandom_range(0, 70));
        if (e < 0) e = 0;
        if (e > 65535) e = 65535;
        return e[15:0];
      end
      2: return 16'($urandom);
      default: return 16'hFFFF - 16'($urandom_range(0, 70));
    endcase
  endfunction

  task automatic run_random(input int count, input bit pause_midway);
    for (int i = 0; i < count; i++) begin
      // once, let the pipe run dry before carrying on
      if (pause_midway && i == count / 2) drain_cells();
      send_number(pick_coord(board.frame_w), pick_coord(board.frame_h), pick_number());
    end
  endtask

  initial begin : main_flow
    logic [15:0] fw_set[6];
    logic [15:0] fh_set[6];
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_index       = dngr_pkg::CFG_FRAME_WIDTH;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_origin_x     = '0;
    in_origin_y     = '0;
    in_number_value = '0;
    quiet           = 1'b0;
    board           = new();

    // frame settings per phase: zero frame, full range, random, tiny, thin, reset size
    fw_set = '{16'd0, 16'hFFFF, 16'd0, 16'd37, 16'd1, 16'd640};
    fh_set = '{16'd0, 16'hFFFF, 16'd0, 16'd3, 16'hFFFF, 16'd480};
    fw_set[2] = 16'($urandom_range(1, 65534));
    fh_set[2] = 16'($urandom_range(1, 65534));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed words against the reset frame of 640 x 480
    send_number(16'd0, 16'd0, 32'd0);                  // zero gives one digit
    send_number(16'd0, 16'd0, 32'd9);
    send_number(16'd6, 16'd7, 32'd10);
    send_number(16'd100, 16'd100, 32'd1234567890);     // every digit once
    send_number(16'd200, 16'd200, 32'd987654321);
    send_number(16'd0, 16'd0, 32'd1000000000);         // ten digits, many zeros
    send_number(16'd300, 16'd300, 32'hFFFF_FFFF);      // largest value
    send_number(16'd630, 16'd10, 32'd12345);           // right edge cuts cells
    send_number(16'd10, 16'd476, 32'd67890);           // bottom edge cuts rows
    send_number(16'd636, 16'd476, 32'd55555);          // both edges
    send_number(16'd639, 16'd479, 32'd8);              // only the top-left pixel is inside, unlit for 8
    send_number(16'hFFFF, 16'd0, 32'd1);
    send_number(16'd0, 16'hFFFF, 32'd2);
    send_number(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);    // cell_x runs past 16 bits
    send_number(16'd640, 16'd0, 32'd4);                // starts just outside
    drain_cells();

    for (int p = 0; p < 6; p++) begin
      if (p == 5) quiet = 1'b1;
      write_frame_reg(dngr_pkg::CFG_FRAME_WIDTH, fw_set[p]);
      write_frame_reg(dngr_pkg::CFG_FRAME_HEIGHT, fh_set[p]);
      if (p == 1) begin
        // rows and columns past the 16-bit range are clipped, never wrapped
        send_number(16'hFFFF, 16'hFFFF, 32'd8);
        send_number(16'hFFF0, 16'hFFF8, 32'hFFFF_FFFF);
      end
      run_random(44, p == 2);
      drain_cells();
    end

    if (board.pending() != 0)
      $display("%0d expected digit cells never arrived", board.pending());
    if (board.pending() == 0 && board.fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/dngr_pkg.sv
rtl/decimal_number_glyph_renderer_core.sv
verif/tb.sv
